FILE: src/csb_pkg.sv
// ----------------------------------------------------------------------------
// Clipped sprite blit package
// Shared constants, register indexes and structures of the sprite blit unit.
// ----------------------------------------------------------------------------
package csb_pkg;

  // Frame buffer geometry.
  localparam int unsigned SCREEN_WIDTH  = 320;
  localparam int unsigned SCREEN_HEIGHT = 200;

  // Field widths.
  localparam int unsigned COORD_W = 16;
  localparam int unsigned SIZE_W  = 10;
  localparam int unsigned PIX_W   = 32;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned GRAY_W  = 24;
  localparam int unsigned CHAN_W  = 8;

  localparam logic [CHAN_W-1:0] GRAY_MAX = 8'hFF;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    CFG_DEST_X        = 2'd0,
    CFG_DEST_Y        = 2'd1,
    CFG_SPRITE_WIDTH  = 2'd2,
    CFG_SPRITE_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] dest_x;
    logic signed [COORD_W-1:0] dest_y;
    logic [SIZE_W-1:0]         width;
    logic [SIZE_W-1:0]         height;
  } cfg_t;

  // Walk position within the current sprite.
  typedef struct packed {
    logic [SIZE_W-1:0] col;
    logic [SIZE_W-1:0] row;
    logic              done;
  } pos_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] addr;
    logic [GRAY_W-1:0] gray;
  } result_t;

endpackage

FILE: src/clipped_sprite_blit_unit.sv
// ----------------------------------------------------------------------------
// Clipped sprite blit unit
// Streams sprite pixels onto a fixed frame buffer with clipping and
// transparency, producing one frame buffer write request per visible pixel.
// ----------------------------------------------------------------------------
// The unit takes one source pixel request per cycle in row-major order and
// keeps the sprite column and row itself; a request carrying the start flag
// restarts the walk at the top left corner. Each pixel lands at
// (dest_x + column, dest_y + row) on a 320 by 200 frame buffer. A write
// request leaves only for a pixel that is on screen and whose value is
// positive; it carries the word address row * 320 + column and a gray colour
// with the value saturated at 255 in all three bytes. A sprite whose width or
// height is zero or larger than the screen draws nothing, and pixels after
// width times height are dropped until the next start. Every pixel passes
// through the input register and then the result register on its way to the
// write request, with the clipping, address multiply by the screen width and
// position update in between. The next position is formed combinationally,
// so a new pixel is accepted in every cycle while the write side keeps up; a
// stalled write request holds the result register, and the input register
// still takes one more pixel behind it. Configuration
// registers must only be written while no pixel is in flight.
module clipped_sprite_blit_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_index_i,
  input  logic [csb_pkg::COORD_W-1:0]         cfg_data_i,
  // Source pixel requests
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [csb_pkg::PIX_W-1:0]    pixel_value_i,
  input  logic                                start_of_sprite_i,
  // Frame buffer write requests
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [csb_pkg::ADDR_W-1:0]          fb_address_o,
  output logic [csb_pkg::GRAY_W-1:0]          gray_color_o
);

  csb_pkg::cfg_t    cfg_q;
  csb_pkg::pos_t    pos_q;
  csb_pkg::pos_t    pos_d;
  csb_pkg::result_t res_d;

  logic                        s1_valid_q;
  logic [csb_pkg::PIX_W-1:0]   s1_pix_q;
  logic                        s1_start_q;

  logic                        out_valid_q;
  logic [csb_pkg::ADDR_W-1:0]  out_addr_q;
  logic [csb_pkg::GRAY_W-1:0]  out_gray_q;

  logic out_load;
  logic s1_fire;
  logic in_accept;

  // The result register may load when it is empty or its request is taken.
  assign out_load   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_load;
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (csb_pkg::cfg_idx_e'(cfg_index_i))
        csb_pkg::CFG_DEST_X:        cfg_q.dest_x <= $signed(cfg_data_i);
        csb_pkg::CFG_DEST_Y:        cfg_q.dest_y <= $signed(cfg_data_i);
        csb_pkg::CFG_SPRITE_WIDTH:  cfg_q.width  <= cfg_data_i[csb_pkg::SIZE_W-1:0];
        csb_pkg::CFG_SPRITE_HEIGHT: cfg_q.height <= cfg_data_i[csb_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q   <= pixel_value_i;
      s1_start_q <= start_of_sprite_i;
    end
  end

  csb_pixel_eval u_eval (
    .cfg_i         (cfg_q),
    .pos_i         (pos_q),
    .pixel_value_i (s1_pix_q),
    .start_i       (s1_start_q),
    .pos_o         (pos_d),
    .result_o      (res_d)
  );

  // Walk position; nothing is drawn until the first start after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q.col  <= '0;
      pos_q.row  <= '0;
      pos_q.done <= 1'b1;
    end else if (s1_fire) begin
      pos_q <= pos_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_fire && res_d.hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && res_d.hit) begin
      out_addr_q <= res_d.addr;
      out_gray_q <= res_d.gray;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign fb_address_o = out_addr_q;
  assign gray_color_o = out_gray_q;

`ifndef NO_ASSERTIONS
  // Every write request addresses a word inside the frame buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(fb_address_o) <
                     csb_pkg::SCREEN_WIDTH * csb_pkg::SCREEN_HEIGHT))
    else $error("frame buffer address out of range");

  // The colour is a non-black gray with three equal bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (gray_color_o[7:0] != '0) &&
                    (gray_color_o[15:8] == gray_color_o[7:0]) &&
                    (gray_color_o[23:16] == gray_color_o[7:0]))
    else $error("gray colour malformed");

  // A held pixel in the input register keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_fire |=> s1_valid_q && $stable(s1_pix_q) && $stable(s1_start_q))
    else $error("input register lost a pending pixel");

  // A finished sprite stays finished until a start arrives.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && pos_q.done && !s1_start_q |=> pos_q.done)
    else $error("walk resumed without a start");

  // A pixel of a sprite with zero width or height ends the sprite.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && ((cfg_q.width == '0) || (cfg_q.height == '0)) |=> pos_q.done)
    else $error("empty sprite did not end the walk");
`endif

endmodule

FILE: src/csb_pixel_eval.sv
// ----------------------------------------------------------------------------
// Sprite pixel evaluation
// Clips one source pixel, forms its frame buffer address and gray colour, and
// works out the next walk position.
// ----------------------------------------------------------------------------
module csb_pixel_eval (
  input  csb_pkg::cfg_t               cfg_i,
  input  csb_pkg::pos_t               pos_i,
  input  logic [csb_pkg::PIX_W-1:0]   pixel_value_i,
  input  logic                        start_i,
  output csb_pkg::pos_t               pos_o,
  output csb_pkg::result_t            result_o
);

  localparam logic [csb_pkg::SIZE_W-1:0] ScrW = csb_pkg::SIZE_W'(csb_pkg::SCREEN_WIDTH);
  localparam logic [csb_pkg::SIZE_W-1:0] ScrH = csb_pkg::SIZE_W'(csb_pkg::SCREEN_HEIGHT);

  logic [csb_pkg::SIZE_W-1:0]        col_eff;
  logic [csb_pkg::SIZE_W-1:0]        row_eff;
  logic                              done_eff;
  logic                              size_bad;
  logic signed [csb_pkg::COORD_W:0]  sx;
  logic signed [csb_pkg::COORD_W:0]  sy;
  logic                              on_screen;
  logic                              opaque;
  logic [2*csb_pkg::SIZE_W-1:0]      row_base;
  logic [csb_pkg::CHAN_W-1:0]        level;
  logic                              col_last;
  logic                              row_last;

  always_comb begin
    // A start flag restarts the walk at the top left corner.
    col_eff  = start_i ? '0 : pos_i.col;
    row_eff  = start_i ? '0 : pos_i.row;
    done_eff = start_i ? 1'b0 : pos_i.done;

    size_bad = (cfg_i.width == '0) || (cfg_i.height == '0) ||
               (cfg_i.width > ScrW) || (cfg_i.height > ScrH);

    sx = {cfg_i.dest_x[csb_pkg::COORD_W-1], cfg_i.dest_x} +
         $signed({{(csb_pkg::COORD_W+1-csb_pkg::SIZE_W){1'b0}}, col_eff});
    sy = {cfg_i.dest_y[csb_pkg::COORD_W-1], cfg_i.dest_y} +
         $signed({{(csb_pkg::COORD_W+1-csb_pkg::SIZE_W){1'b0}}, row_eff});

    on_screen = !sx[csb_pkg::COORD_W] && !sy[csb_pkg::COORD_W] &&
                (sx[csb_pkg::COORD_W-1:0] < csb_pkg::COORD_W'(csb_pkg::SCREEN_WIDTH)) &&
                (sy[csb_pkg::COORD_W-1:0] < csb_pkg::COORD_W'(csb_pkg::SCREEN_HEIGHT));

    opaque = !pixel_value_i[csb_pkg::PIX_W-1] &&
             (pixel_value_i[csb_pkg::PIX_W-2:0] != '0);

    // Row is below the screen height once on screen, so its low bits suffice.
    row_base = sy[csb_pkg::SIZE_W-1:0] * ScrW;

    level = (pixel_value_i[csb_pkg::PIX_W-2:csb_pkg::CHAN_W] != '0) ?
            csb_pkg::GRAY_MAX : pixel_value_i[csb_pkg::CHAN_W-1:0];

    result_o.hit  = !done_eff && !size_bad && on_screen && opaque;
    result_o.addr = row_base[csb_pkg::ADDR_W-1:0] + sx[csb_pkg::ADDR_W-1:0];
    result_o.gray = {level, level, level};

    col_last = ({1'b0, col_eff} + 11'd1) >= {1'b0, cfg_i.width};
    row_last = ({1'b0, row_eff} + 11'd1) >= {1'b0, cfg_i.height};

    pos_o.col  = col_eff;
    pos_o.row  = row_eff;
    pos_o.done = done_eff;
    if (done_eff) begin
      pos_o.done = 1'b1;
    end else if (size_bad) begin
      pos_o.done = 1'b1;
    end else if (col_last) begin
      pos_o.col = '0;
      if (row_last) begin
        pos_o.row  = '0;
        pos_o.done = 1'b1;
      end else begin
        pos_o.row = row_eff + 10'd1;
      end
    end else begin
      pos_o.col = col_eff + 10'd1;
    end
  end

endmodule
